// File: sv/fcsg_pkg.sv
// types, constants and tables shared by the filled circle span generator
`default_nettype none

package fcsg_pkg;

  localparam int MAX_RADIUS = 21;
  localparam int ImaxNum = 707;
  localparam int ImaxDen = 1000;
  localparam int RowLimitDepth = 32;

  typedef struct packed {
    logic [15:0] center_x;
    logic [15:0] center_y;
    logic [4:0]  radius;
    logic [15:0] fill_color;
  } req_t;

  typedef struct packed {
    logic [15:0] span_x;
    logic [15:0] span_y;
    logic [5:0]  span_len;
    logic [15:0] span_color;
    logic        last_span;
  } span_t;

  typedef enum logic [2:0] {
    SPAN_NONE,
    SPAN_CENTER,
    SPAN_OUTER_LO,
    SPAN_OUTER_HI,
    SPAN_INNER_LO,
    SPAN_INNER_HI
  } span_sel_t;

  typedef struct packed {
    logic      load;
    span_sel_t emit;
    logic      dec_x;
    logic      inc_i;
    logic      flush;
  } cmd_t;

  typedef struct packed {
    logic req_zero;
    logic over_bound;
    logic outer_ok;
    logic step_last;
  } sts_t;

  typedef logic [4:0] row_limit_t [RowLimitDepth];

  // last step index per radius: floor(r * 707 / 1000) + 1
  function automatic row_limit_t build_row_limit();
    row_limit_t tbl;
    for (int k = 0; k < RowLimitDepth; k++) begin
      tbl[k] = 5'((k * ImaxNum) / ImaxDen + 1);
    end
    return tbl;
  endfunction

  localparam row_limit_t ROW_LIMIT = build_row_limit();

endpackage

`default_nettype wire

// File: sv/fcsg_datapath.sv
// datapath: request registers, step and edge counters, span build and output stage
`default_nettype none

module fcsg_datapath #(
  parameter int MAX_RADIUS = fcsg_pkg::MAX_RADIUS
) (
  input  wire               clk,
  input  wire               rst,
  input  fcsg_pkg::req_t    req,
  input  fcsg_pkg::cmd_t    cmd,
  output fcsg_pkg::sts_t    sts,
  output logic              span_valid,
  output fcsg_pkg::span_t   span
);
  import fcsg_pkg::*;

  logic [15:0] cx;
  logic [15:0] cy;
  logic [15:0] color;
  logic [4:0]  r;
  logic [4:0]  imax;
  logic [8:0]  sqmax;
  logic [4:0]  i;
  logic [4:0]  x;

  logic [4:0]  r_sat;
  logic [9:0]  r_sq;
  logic [9:0]  ii;
  logic [9:0]  xx;
  logic [10:0] sq_sum;

  span_t cand;
  logic  cand_ok;
  span_t held;
  logic  held_valid;

  assign r_sat = (req.radius > 5'(MAX_RADIUS)) ? 5'(MAX_RADIUS) : req.radius;
  assign r_sq  = r_sat * r_sat;

  assign ii     = i * i;
  assign xx     = x * x;
  assign sq_sum = {1'b0, ii} + {1'b0, xx};

  assign sts.req_zero   = (req.radius == 5'd0);
  assign sts.over_bound = (sq_sum > {2'b00, sqmax});
  assign sts.outer_ok   = (x > imax);
  assign sts.step_last  = (i == imax);

  always_comb begin
    cand = '0;
    cand.span_color = color;
    case (cmd.emit)
      SPAN_CENTER: begin
        cand.span_x   = cx - {11'd0, r};
        cand.span_y   = cy;
        cand.span_len = {r, 1'b0};
      end
      SPAN_OUTER_LO: begin
        cand.span_x   = cx - {11'd0, i} + 16'd1;
        cand.span_y   = cy + {11'd0, x};
        cand.span_len = {i - 5'd1, 1'b0};
      end
      SPAN_OUTER_HI: begin
        cand.span_x   = cx - {11'd0, i} + 16'd1;
        cand.span_y   = cy - {11'd0, x};
        cand.span_len = {i - 5'd1, 1'b0};
      end
      SPAN_INNER_LO: begin
        cand.span_x   = cx - {11'd0, x};
        cand.span_y   = cy + {11'd0, i};
        cand.span_len = {x, 1'b0};
      end
      SPAN_INNER_HI: begin
        cand.span_x   = cx - {11'd0, x};
        cand.span_y   = cy - {11'd0, i};
        cand.span_len = {x, 1'b0};
      end
      default: begin
        cand.span_len = 6'd0;
      end
    endcase
  end

  assign cand_ok = (cmd.emit != SPAN_NONE) && (cand.span_len != 6'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      span_valid <= 1'b0;
    end else begin
      span_valid <= 1'b0;
      if (cand_ok) begin
        held_valid <= 1'b1;
        span_valid <= held_valid;
      end else if (cmd.flush) begin
        held_valid <= 1'b0;
        span_valid <= held_valid;
      end
    end
  end

  // one span is held back so the final one can carry the last flag
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx    <= req.center_x;
      cy    <= req.center_y;
      color <= req.fill_color;
      r     <= r_sat;
      imax  <= ROW_LIMIT[r_sat];
      sqmax <= 9'(r_sq + {6'd0, r_sat[4:1]});
      x     <= r_sat;
      i     <= 5'd1;
    end else begin
      if (cmd.dec_x && (x != 5'd0)) begin
        x <= x - 5'd1;
      end
      if (cmd.inc_i) begin
        i <= i + 5'd1;
      end
    end
    if (cand_ok) begin
      held <= cand;
      span <= held;
    end else if (cmd.flush) begin
      span <= {held.span_x, held.span_y, held.span_len, held.span_color, 1'b1};
    end
  end

endmodule

`default_nettype wire

// File: sv/fcsg_ctrl.sv
// controller: sequences the centre row, the per-step checks and the span order
`default_nettype none

module fcsg_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              start,
  input  fcsg_pkg::sts_t   sts,
  output fcsg_pkg::cmd_t   cmd,
  output logic             busy
);
  import fcsg_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CENTER,
    ST_CHECK,
    ST_OUTER_HI,
    ST_INNER_LO,
    ST_INNER_HI,
    ST_FLUSH
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = (state != ST_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.emit   = SPAN_NONE;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = sts.req_zero ? ST_IDLE : ST_CENTER;
        end
      end
      ST_CENTER: begin
        cmd.emit   = SPAN_CENTER;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts.over_bound && sts.outer_ok) begin
          cmd.emit   = SPAN_OUTER_LO;
          state_next = ST_OUTER_HI;
        end else begin
          cmd.dec_x  = sts.over_bound;
          state_next = ST_INNER_LO;
        end
      end
      ST_OUTER_HI: begin
        cmd.emit   = SPAN_OUTER_HI;
        cmd.dec_x  = 1'b1;
        state_next = ST_INNER_LO;
      end
      ST_INNER_LO: begin
        cmd.emit   = SPAN_INNER_LO;
        state_next = ST_INNER_HI;
      end
      ST_INNER_HI: begin
        cmd.emit = SPAN_INNER_HI;
        if (sts.step_last) begin
          state_next = ST_FLUSH;
        end else begin
          cmd.inc_i  = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_FLUSH: begin
        cmd.flush  = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// File: sv/filled_circle_span_generator_unit.sv
// top level of the filled circle span generator
//
// A request (centre, radius, colour) is transferred on req at a rising edge
// where start is high and busy is low. The block then produces the spans that
// fill the disc: the centre row first, then for each step the outer row pair
// (when the edge moves in and is still beyond row imax) and the inner row pair, lower row before upper.
// Each span is shown on span for exactly one cycle with span_valid high; the
// final span of a circle has last_span set. Zero-length spans are dropped.
// A radius of zero gives no spans; a radius above 21 is treated as 21.
// There are imax = floor(r*0.707) + 1 steps. The controller walks one span
// slot per cycle, and one span is held back so the last flag can be set;
// the last span is shown in the first cycle with busy low. The receiver
// cannot stall the output. Reset clears the controller to idle and drops
// any held span.
`default_nettype none

module filled_circle_span_generator_unit #(
  parameter int MAX_RADIUS = fcsg_pkg::MAX_RADIUS
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              start,
  output logic             busy,
  input  fcsg_pkg::req_t   req,
  output logic             span_valid,
  output fcsg_pkg::span_t  span
);
  import fcsg_pkg::*;

  cmd_t cmd;
  sts_t sts;

  fcsg_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  fcsg_datapath #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .cmd        (cmd),
    .sts        (sts),
    .span_valid (span_valid),
    .span       (span)
  );

`ifndef NO_ASSERTIONS
  a_no_empty_span: assert property (@(posedge clk) disable iff (rst)
    span_valid |-> (span.span_len != 6'd0))
    else $error("zero-length span transferred");

  a_last_after_done: assert property (@(posedge clk) disable iff (rst)
    (span_valid && span.last_span) |-> !busy)
    else $error("last span while still working");

  a_mid_span_busy: assert property (@(posedge clk) disable iff (rst)
    (span_valid && !span.last_span) |-> busy)
    else $error("non-last span after circle done");

  a_zero_radius_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (req.radius == 5'd0)) |=> (!busy && !span_valid))
    else $error("zero radius request started work");
`endif

endmodule

`default_nettype wire

// File: dv/fcsg_span_checker.sv
`timescale 1ns / 100ps
// span checker: predicts the fill spans of each circle request and compares them
module fcsg_span_checker (
  input  wire             clk,
  input  wire             rst,
  input  wire             start,
  input  wire             busy,
  input  fcsg_pkg::req_t  req,
  input  wire             span_valid,
  input  fcsg_pkg::span_t span,
  output int              errors,
  output int              pending
);
  import fcsg_pkg::*;

  span_t fill_spans[$];
  span_t want;

  initial begin
    errors = 0;
    pending = 0;
  end

  function automatic int push_span(input int x, input int y, input int len,
                                   input logic [15:0] color);
    span_t s;
    if (len == 0) return 0;
    s.span_x = 16'(x);
    s.span_y = 16'(y);
    s.span_len = 6'(len);
    s.span_color = color;
    s.last_span = 1'b0;
    fill_spans.push_back(s);
    return 1;
  endfunction

  function automatic void predict_circle(input req_t rq);
    int r, imax, sqmax, x, n, cx, cy;
    r = rq.radius;
    cx = rq.center_x;
    cy = rq.center_y;
    n = 0;
    if (r == 0) return;
    if (r > MAX_RADIUS) r = MAX_RADIUS;
    imax = (r * 707) / 1000 + 1;
    sqmax = r * r + r / 2;
    x = r;
    n += push_span(cx - r, cy, 2 * r, rq.fill_color);
    for (int i = 1; i <= imax; i++) begin
      if (i * i + x * x > sqmax) begin
        // edge moved in: outer row pair first
        if (x > imax) begin
          n += push_span(cx - i + 1, cy + x, 2 * (i - 1), rq.fill_color);
          n += push_span(cx - i + 1, cy - x, 2 * (i - 1), rq.fill_color);
        end
        if (x > 0) x--;
      end
      n += push_span(cx - x, cy + i, 2 * x, rq.fill_color);
      n += push_span(cx - x, cy - i, 2 * x, rq.fill_color);
    end
    if (n > 0) fill_spans[fill_spans.size() - 1].last_span = 1'b1;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      fill_spans.delete();
    end else begin
      if (span_valid) begin
        if (fill_spans.size() == 0) begin
          errors++;
          $display("%0t: unexpected span: x=%h y=%h len=%0d color=%h last=%b", $time,
                   span.span_x, span.span_y, span.span_len, span.span_color,
                   span.last_span);
        end else begin
          want = fill_spans.pop_front();
          if (span.span_x !== want.span_x || span.span_y !== want.span_y ||
              span.span_len !== want.span_len || span.span_color !== want.span_color ||
              span.last_span !== want.last_span) begin
            errors++;
            $display("%0t: span mismatch: expected x=%h y=%h len=%0d color=%h last=%b",
                     $time, want.span_x, want.span_y, want.span_len, want.span_color,
                     want.last_span);
            $display("%0t:                actual   x=%h y=%h len=%0d color=%h last=%b",
                     $time, span.span_x, span.span_y, span.span_len, span.span_color,
                     span.last_span);
          end
        end
      end
      if (start && !busy) predict_circle(req);
    end
    pending = fill_spans.size();
  end

endmodule

// File: dv/tb_filled_circle_span_generator_unit.sv
`timescale 1ns / 100ps
// testbench top: drives circle requests into the span generator and gives the verdict
module tb_filled_circle_span_generator_unit;
  import fcsg_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int RandomRequests = 346;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  start = 1'b0;
  req_t  req = '0;
  logic  busy;
  logic  span_valid;
  span_t span;
  int    errors;
  int    pending;
  int    idle_cycles = 0;
  logic  no_gaps = 1'b0;

  always #2 clk = ~clk;

  filled_circle_span_generator_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req        (req),
    .span_valid (span_valid),
    .span       (span)
  );

  fcsg_span_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req        (req),
    .span_valid (span_valid),
    .span       (span),
    .errors     (errors),
    .pending    (pending)
  );

  // cycles with no transfer and no span
  always @(posedge clk) begin
    if (rst || (start && !busy) || span_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic req_t make_req(input logic [15:0] cx, input logic [15:0] cy,
                                    input logic [4:0] r, input logic [15:0] color);
    req_t rq;
    rq.center_x = cx;
    rq.center_y = cy;
    rq.radius = r;
    rq.fill_color = color;
    return rq;
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_circle(input req_t rq);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(4);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req = rq;
    start = 1'b1;
    while (busy) @(negedge clk);
    @(negedge clk);
  endtask

  initial begin
    int pick;
    logic [4:0] r;
    logic [15:0] color;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // zero radius, every radius with extreme coordinates, oversized radii
    send_circle(make_req(16'h1234, 16'h5678, 5'd0, 16'hFFFF));
    for (int k = 1; k <= MAX_RADIUS; k++) begin
      color = (k % 3 == 0) ? 16'h0000 : ((k % 3 == 1) ? 16'hFFFF : 16'hA5A5);
      send_circle(make_req((k % 2) ? 16'h0000 : 16'hFFFF, (k % 2) ? 16'hFFFF : 16'h0000,
                           5'(k), color));
    end
    send_circle(make_req(16'h8000, 16'h7FFF, 5'd22, 16'h5A5A));
    send_circle(make_req(16'h0005, 16'hFFFA, 5'd31, 16'hF800));
    send_circle(make_req(16'hFFFF, 16'hFFFF, 5'd0, 16'h0000));

    for (int k = 0; k < RandomRequests; k++) begin
      no_gaps = ((k / 40) % 3 == 1);
      pick = $urandom_range(99);
      if (pick < 4) r = 5'd0;
      else if (pick < 9) r = 5'($urandom_range(31, MAX_RADIUS + 1));
      else if (pick < 40) r = 5'($urandom_range(4, 1));
      else r = 5'($urandom_range(MAX_RADIUS, 1));
      send_circle(make_req(16'($urandom), 16'($urandom), r, 16'($urandom)));
    end
    start = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
